>>> src/sdenv_pkg.sv
// shared types, constants and tables of the step sequencer decay envelope block
package sdenv_pkg;

    // default sizes handed to the top level
    localparam int STEPS_DEF       = 16;
    localparam int SAMPLE_BITS_DEF = 16;

    // configuration port
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_STEP_PERIOD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TUNING       = 2'd3;

    localparam logic [CFG_W-1:0] STEP_PERIOD_RST  = 16'd11025;
    localparam logic [CFG_W-1:0] DECAY_LENGTH_RST = 16'd12403;
    localparam logic [CFG_W-1:0] VOLUME_RST       = 16'd0;
    localparam logic [CFG_W-1:0] TUNING_RST       = 16'd16384;

    // item opcodes
    localparam logic OP_FRAME   = 1'b0;
    localparam logic OP_PATTERN = 1'b1;

    // pattern and envelope limits
    localparam int             SEL_W      = 4;
    localparam int             NOTE_W     = 4;
    localparam logic [3:0]     NOTE_MAX   = 4'd12;
    localparam int             IDX_W      = 16;
    localparam logic [15:0]    IDX_MAX    = 16'd65535;
    localparam logic [15:0]    ATTACK_END = 16'd30;
    localparam int             GAIN_W     = 16;
    localparam int             QUO_BITS   = 15;

    // frequency path
    localparam int          FREQ_W   = 18;
    localparam logic [19:0] FREQ_MAX = 20'd262143;
    localparam int          FPROD_W  = 32;

    // sample scaling: gain times volume, then sample times that, then >> 30
    localparam int GAIN_PROD_BITS = 32;
    localparam int PROD_SHIFT     = 30;

    // one pattern entry
    typedef struct packed {
        logic              gate;
        logic              down;
        logic              up;
        logic [NOTE_W-1:0] note;
    } t_entry;

    // controller to datapath commands
    typedef struct packed {
        logic frame_start;
        logic pat_wr;
        logic setup;
        logic div_take;
        logic vmul;
        logic mul_l;
        logic mul_r;
        logic out_load;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic need_div;
        logic div_done;
    } t_stat;

    // 110 Hz times 2^(n/12), 8 fraction bits
    function automatic logic [15:0] semitone_q8(input logic [NOTE_W-1:0] note);
        logic [15:0] t;
        case (note)
            4'd0:    t = 16'd28160;
            4'd1:    t = 16'd29834;
            4'd2:    t = 16'd31609;
            4'd3:    t = 16'd33488;
            4'd4:    t = 16'd35479;
            4'd5:    t = 16'd37589;
            4'd6:    t = 16'd39824;
            4'd7:    t = 16'd42192;
            4'd8:    t = 16'd44701;
            4'd9:    t = 16'd47359;
            4'd10:   t = 16'd50175;
            4'd11:   t = 16'd53159;
            default: t = 16'd56320;
        endcase
        return t;
    endfunction

    // attack ramp floor(i * 32768 / 20), reaches unity at twenty
    localparam logic [GAIN_W-1:0] ATTACK_GAIN [21] = '{
        16'd0,     16'd1638,  16'd3276,  16'd4915,  16'd6553,  16'd8192,
        16'd9830,  16'd11468, 16'd13107, 16'd14745, 16'd16384, 16'd18022,
        16'd19660, 16'd21299, 16'd22937, 16'd24576, 16'd26214, 16'd27852,
        16'd29491, 16'd31129, 16'd32768
    };

    function automatic logic [GAIN_W-1:0] attack_gain(input logic [4:0] i);
        logic [GAIN_W-1:0] g;
        if (i > 5'd20) begin
            g = 16'd32768;
        end else begin
            g = ATTACK_GAIN[i];
        end
        return g;
    endfunction

endpackage

>>> src/sdenv_div.sv
// restoring divider for the decay gain: floor(num * 2^15 / den), num below den
module sdenv_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [sdenv_pkg::CFG_W-1:0]         i_dividend,
    input  logic [sdenv_pkg::CFG_W-1:0]         i_divisor,
    output logic                                o_done,
    output logic [sdenv_pkg::QUO_BITS-1:0]      o_quotient
);

    localparam int W  = sdenv_pkg::CFG_W;
    localparam int QB = sdenv_pkg::QUO_BITS;
    localparam int CW = $clog2(QB);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_count;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_den;
    logic [QB-1:0] r_quo;

    logic [W:0]    w_shift;
    logic [W:0]    w_trial;
    logic          w_fit;

    // one quotient bit per cycle
    assign w_shift = {r_rem, 1'b0};
    assign w_trial = w_shift - {1'b0, r_den};
    assign w_fit   = w_shift >= {1'b0, r_den};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_count <= '0;
            end else if (r_busy) begin
                r_count <= r_count + CW'(1);
                if (r_count == CW'(QB - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend;
            r_den <= i_divisor;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= w_fit ? w_trial[W-1:0] : w_shift[W-1:0];
            r_quo <= {r_quo[QB-2:0], w_fit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

>>> src/sdenv_ctrl.sv
// controller state machine: item handshake, sequencing of the datapath, output valid
module sdenv_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_op,
    output logic              o_valid,
    input  logic              i_stall,
    output sdenv_pkg::t_cmd   o_cmd,
    input  sdenv_pkg::t_stat  i_stat
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SETUP = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_VMUL  = 3'd3;
    localparam logic [2:0] S_MUL_L = 3'd4;
    localparam logic [2:0] S_MUL_R = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]      r_state;
    logic [2:0]      n_state;
    logic            r_out_valid;
    logic            n_out_valid;
    sdenv_pkg::t_cmd w_cmd;

    // next state and commands
    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_op == sdenv_pkg::OP_PATTERN) begin
                        w_cmd.pat_wr = 1'b1;
                    end else begin
                        w_cmd.frame_start = 1'b1;
                        n_state           = S_SETUP;
                    end
                end
            end
            S_SETUP: begin
                w_cmd.setup = 1'b1;
                n_state     = i_stat.need_div ? S_DIV : S_VMUL;
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    w_cmd.div_take = 1'b1;
                    n_state        = S_VMUL;
                end
            end
            S_VMUL: begin
                w_cmd.vmul = 1'b1;
                n_state    = S_MUL_L;
            end
            S_MUL_L: begin
                w_cmd.mul_l = 1'b1;
                n_state     = S_MUL_R;
            end
            S_MUL_R: begin
                w_cmd.mul_r = 1'b1;
                n_state     = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || !i_stall) begin
                    w_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output register valid: load wins, otherwise hold until taken
    always_comb begin
        if (w_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else begin
            n_out_valid = r_out_valid && i_stall;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_cmd   = w_cmd;

`ifndef NO_ASSERTIONS
    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!r_out_valid || !i_stall))
        else $error("result loaded over a pending result");

    // a loaded result is presented in the next cycle
    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |=> r_out_valid)
        else $error("loaded result not presented");

    // a frame always goes to setup next
    a_frame_setup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.frame_start |=> (r_state == S_SETUP))
        else $error("frame did not enter setup");

    // divider completion moves on to the gain multiply
    a_div_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && i_stat.div_done) |=> (r_state == S_VMUL))
        else $error("divider result not taken");
`endif

endmodule

>>> src/sdenv_dp.sv
// datapath: config registers, pattern store, step timer, envelope, frequency and scaling
module sdenv_dp #(
    parameter int STEPS       = sdenv_pkg::STEPS_DEF,
    parameter int SAMPLE_BITS = sdenv_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  sdenv_pkg::t_cmd                       i_cmd,
    output sdenv_pkg::t_stat                      o_stat,
    input  logic                                  i_cfg_we,
    input  logic [sdenv_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [sdenv_pkg::CFG_W-1:0]           i_cfg_data,
    input  logic signed [SAMPLE_BITS-1:0]         i_left_in,
    input  logic signed [SAMPLE_BITS-1:0]         i_right_in,
    input  logic [sdenv_pkg::SEL_W-1:0]           i_step_select,
    input  logic [sdenv_pkg::NOTE_W-1:0]          i_step_note,
    input  logic                                  i_step_up,
    input  logic                                  i_step_down,
    input  logic                                  i_step_gate,
    output logic signed [SAMPLE_BITS-1:0]         o_left_out,
    output logic signed [SAMPLE_BITS-1:0]         o_right_out,
    output logic [sdenv_pkg::FREQ_W-1:0]          o_osc_freq,
    output logic                                  o_step_advanced,
    output logic [sdenv_pkg::SEL_W-1:0]           o_playing_step
);

    localparam int SW = $clog2(STEPS);
    localparam int PW = SAMPLE_BITS + sdenv_pkg::GAIN_PROD_BITS + 1;
    localparam int QW = PW - sdenv_pkg::PROD_SHIFT;
    localparam int GW = sdenv_pkg::GAIN_W;

    // configuration registers
    logic [15:0] r_step_period;
    logic [15:0] r_decay;
    logic [15:0] r_volume;
    logic [15:0] r_tuning;

    // sequencer and envelope state
    sdenv_pkg::t_entry               r_pattern [STEPS];
    logic [15:0]                     r_frame_timer;
    logic [SW-1:0]                   r_step_cnt;
    logic [15:0]                     r_env_idx;
    logic [sdenv_pkg::FREQ_W-1:0]    r_latched_freq;
    logic [SW-1:0]                   r_latched_step;

    // per-frame working registers
    logic signed [SAMPLE_BITS-1:0]   r_left;
    logic signed [SAMPLE_BITS-1:0]   r_right;
    sdenv_pkg::t_entry               r_entry;
    logic                            r_adv;
    logic [sdenv_pkg::FPROD_W-1:0]   r_fprod;
    logic [GW-1:0]                   r_gain;
    logic [sdenv_pkg::GAIN_PROD_BITS-1:0] r_gain_vol;
    logic signed [PW-1:0]            r_prod_l;
    logic signed [PW-1:0]            r_prod_r;

    // output register
    logic signed [SAMPLE_BITS-1:0]   r_left_out;
    logic signed [SAMPLE_BITS-1:0]   r_right_out;
    logic [sdenv_pkg::FREQ_W-1:0]    r_osc_freq;
    logic                            r_step_advanced;
    logic [SW-1:0]                   r_playing_step;

    logic [16:0]                     w_timer_inc;
    logic                            w_adv;
    sdenv_pkg::t_entry               w_cur_entry;
    sdenv_pkg::t_entry               w_wr_entry;
    logic [SW-1:0]                   w_step_next;
    logic [15:0]                     w_idx_base;
    logic [15:0]                     w_idx_new;
    logic                            w_idx_ge;
    logic                            w_attack;
    logic                            w_need_div;
    logic [GW-1:0]                   w_gain_direct;
    logic [sdenv_pkg::FPROD_W-1:0]   w_fprod;
    logic [32:0]                     w_rnd;
    logic [32:0]                     w_fsum;
    logic [19:0]                     w_fshift;
    logic [sdenv_pkg::FREQ_W-1:0]    w_freq_sat;
    logic signed [PW-1:0]            w_mul_a;
    logic signed [PW-1:0]            w_mul_b;
    logic signed [PW-1:0]            w_prod;
    logic                            w_div_done;
    logic [sdenv_pkg::QUO_BITS-1:0]  w_quo;

    // clip the shifted product to the sample range
    function automatic logic [SAMPLE_BITS-1:0] clip(input logic [QW-1:0] q);
        logic [QW-SAMPLE_BITS:0] g;
        logic [SAMPLE_BITS-1:0]  r;
        g = q[QW-1:SAMPLE_BITS-1];
        if ((&g) || !(|g)) begin
            r = q[SAMPLE_BITS-1:0];
        end else if (q[QW-1]) begin
            r = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end else begin
            r = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
        return r;
    endfunction

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_period <= sdenv_pkg::STEP_PERIOD_RST;
            r_decay       <= sdenv_pkg::DECAY_LENGTH_RST;
            r_volume      <= sdenv_pkg::VOLUME_RST;
            r_tuning      <= sdenv_pkg::TUNING_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                sdenv_pkg::CFG_STEP_PERIOD:  r_step_period <= i_cfg_data;
                sdenv_pkg::CFG_DECAY_LENGTH: r_decay       <= i_cfg_data;
                sdenv_pkg::CFG_VOLUME:       r_volume      <= i_cfg_data;
                sdenv_pkg::CFG_TUNING:       r_tuning      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // step timer, step advance and envelope index for a frame
    assign w_timer_inc = {1'b0, r_frame_timer} + 17'd1;
    assign w_adv       = w_timer_inc >= {1'b0, r_step_period};
    assign w_cur_entry = r_pattern[r_step_cnt];
    assign w_step_next = (r_step_cnt == SW'(STEPS - 1)) ? '0 : r_step_cnt + SW'(1);
    assign w_idx_base  = (w_adv && w_cur_entry.gate) ? '0 : r_env_idx;
    assign w_idx_new   = (w_idx_base == sdenv_pkg::IDX_MAX) ? w_idx_base
                                                            : w_idx_base + 16'd1;

    // pattern entry from a write item, note clamped to an octave
    always_comb begin
        w_wr_entry.gate = i_step_gate;
        w_wr_entry.down = i_step_down;
        w_wr_entry.up   = i_step_up;
        w_wr_entry.note = (i_step_note > sdenv_pkg::NOTE_MAX) ? sdenv_pkg::NOTE_MAX
                                                              : i_step_note;
    end

    // sequencer state and pattern store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_timer  <= '0;
            r_step_cnt     <= '0;
            r_env_idx      <= '0;
            r_latched_freq <= '0;
            r_latched_step <= '0;
            for (int k = 0; k < STEPS; k++) begin
                r_pattern[SW'(k)] <= '{gate: 1'b1, down: 1'b0, up: 1'b0, note: '0};
            end
        end else begin
            if (i_cmd.pat_wr && (int'(i_step_select) < STEPS)) begin
                r_pattern[SW'(i_step_select)] <= w_wr_entry;
            end
            if (i_cmd.frame_start) begin
                r_frame_timer <= w_adv ? '0 : w_timer_inc[15:0];
                r_env_idx     <= w_idx_new;
                if (w_adv) begin
                    r_step_cnt     <= w_step_next;
                    r_latched_step <= r_step_cnt;
                end
            end
            if (i_cmd.vmul && r_adv) begin
                r_latched_freq <= w_freq_sat;
            end
        end
    end

    // gain classification: past decay, attack ramp, or divide
    assign w_idx_ge      = r_env_idx >= r_decay;
    assign w_attack      = r_env_idx <= sdenv_pkg::ATTACK_END;
    assign w_need_div    = !w_idx_ge && !w_attack;
    assign w_gain_direct = w_idx_ge ? '0 : sdenv_pkg::attack_gain(r_env_idx[4:0]);

    sdenv_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.setup && w_need_div),
        .i_dividend (r_decay - r_env_idx),
        .i_divisor  (r_decay),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    // frequency: table times tuning, rounded shift by 13, 14 or 15, saturated
    assign w_fprod = {16'd0, sdenv_pkg::semitone_q8(r_entry.note)} * {16'd0, r_tuning};

    always_comb begin
        case ({r_entry.up, r_entry.down})
            2'b10:   w_rnd = 33'h0_0000_1000;
            2'b01:   w_rnd = 33'h0_0000_4000;
            default: w_rnd = 33'h0_0000_2000;
        endcase
        w_fsum = {1'b0, r_fprod} + w_rnd;
        case ({r_entry.up, r_entry.down})
            2'b10:   w_fshift = w_fsum[32:13];
            2'b01:   w_fshift = {2'b00, w_fsum[32:15]};
            default: w_fshift = {1'b0, w_fsum[32:14]};
        endcase
        w_freq_sat = (w_fshift > sdenv_pkg::FREQ_MAX) ? sdenv_pkg::FREQ_MAX[17:0]
                                                     : w_fshift[17:0];
    end

    // shared sample multiplier, left then right
    assign w_mul_a = PW'(i_cmd.mul_r ? r_right : r_left);
    assign w_mul_b = PW'($signed({1'b0, r_gain_vol}));
    assign w_prod  = w_mul_a * w_mul_b;

    // per-frame working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.frame_start) begin
            r_left  <= i_left_in;
            r_right <= i_right_in;
            r_entry <= w_cur_entry;
            r_adv   <= w_adv;
        end
        if (i_cmd.setup) begin
            r_fprod <= w_fprod;
            if (!w_need_div) begin
                r_gain <= w_gain_direct;
            end
        end
        if (i_cmd.div_take) begin
            r_gain <= {1'b0, w_quo};
        end
        if (i_cmd.vmul) begin
            r_gain_vol <= {16'd0, r_gain} * {16'd0, r_volume};
        end
        if (i_cmd.mul_l) begin
            r_prod_l <= w_prod;
        end
        if (i_cmd.mul_r) begin
            r_prod_r <= w_prod;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_left_out      <= clip(r_prod_l[PW-1:sdenv_pkg::PROD_SHIFT]);
            r_right_out     <= clip(r_prod_r[PW-1:sdenv_pkg::PROD_SHIFT]);
            r_osc_freq      <= r_latched_freq;
            r_step_advanced <= r_adv;
            r_playing_step  <= r_latched_step;
        end
    end

    assign o_stat.need_div = w_need_div;
    assign o_stat.div_done = w_div_done;

    assign o_left_out      = r_left_out;
    assign o_right_out     = r_right_out;
    assign o_osc_freq      = r_osc_freq;
    assign o_step_advanced = r_step_advanced;
    assign o_playing_step  = sdenv_pkg::SEL_W'(r_playing_step);

endmodule

>>> src/step_sequencer_decay_envelope_core.sv
// top level of the step sequencer with attack/decay envelope
//
// Input channel (i_valid / o_stall) takes one item per handshake: a pattern
// write (i_op = 1) stores one step and gives no result; an audio frame
// (i_op = 0) gives exactly one result on the output channel (o_valid / i_stall).
// Configuration is a plain write port (i_cfg_we, i_cfg_index, i_cfg_data),
// to be used only while the block is idle.
// A pattern write leaves the block idle; the next item can be taken in the next cycle.
// A frame passes the setup, gain multiply, left and right multiply and output load
// states when the envelope is in its attack ramp or past its end; when the decay
// gain is needed a divide state follows setup, whose length the 15-bit serial
// divider (one quotient bit per cycle) sets. One frame is worked on at a time:
// no item is taken before its result is loaded; o_stall is high from the cycle
// after a frame is taken until its result is in the output register.
// The output register holds a finished result while the receiver stalls, and
// the block still takes the next item meanwhile; a following result waits in
// the last step until the register is free.
// Synchronous active-low reset restores the register defaults, sets every
// pattern step to note zero with gate on, and clears timer, step and envelope.
module step_sequencer_decay_envelope_core #(
    parameter int STEPS       = sdenv_pkg::STEPS_DEF,
    parameter int SAMPLE_BITS = sdenv_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic                                  i_op,
    input  logic signed [SAMPLE_BITS-1:0]         i_left_in,
    input  logic signed [SAMPLE_BITS-1:0]         i_right_in,
    input  logic [sdenv_pkg::SEL_W-1:0]           i_step_select,
    input  logic [sdenv_pkg::NOTE_W-1:0]          i_step_note,
    input  logic                                  i_step_up,
    input  logic                                  i_step_down,
    input  logic                                  i_step_gate,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [SAMPLE_BITS-1:0]         o_left_out,
    output logic signed [SAMPLE_BITS-1:0]         o_right_out,
    output logic [sdenv_pkg::FREQ_W-1:0]          o_osc_freq,
    output logic                                  o_step_advanced,
    output logic [sdenv_pkg::SEL_W-1:0]           o_playing_step,
    input  logic                                  i_cfg_we,
    input  logic [sdenv_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [sdenv_pkg::CFG_W-1:0]           i_cfg_data
);

    sdenv_pkg::t_cmd  w_cmd;
    sdenv_pkg::t_stat w_stat;

    // controller
    sdenv_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_op    (i_op),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (w_cmd),
        .i_stat  (w_stat)
    );

    // datapath
    sdenv_dp #(
        .STEPS       (STEPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_left_in       (i_left_in),
        .i_right_in      (i_right_in),
        .i_step_select   (i_step_select),
        .i_step_note     (i_step_note),
        .i_step_up       (i_step_up),
        .i_step_down     (i_step_down),
        .i_step_gate     (i_step_gate),
        .o_left_out      (o_left_out),
        .o_right_out     (o_right_out),
        .o_osc_freq      (o_osc_freq),
        .o_step_advanced (o_step_advanced),
        .o_playing_step  (o_playing_step)
    );

endmodule
